// ===== design/bapi_pkg.sv =====
// Shared command codes, status codes and helper functions for the process image.
`timescale 1ns / 1ps

package bapi_pkg;

    localparam int AREA_BYTES_DEF = 1024;

    localparam logic [3:0] CMD_RD_BIT   = 4'd0;
    localparam logic [3:0] CMD_RD_BYTE  = 4'd1;
    localparam logic [3:0] CMD_RD_WORD  = 4'd2;
    localparam logic [3:0] CMD_RD_DWORD = 4'd3;
    localparam logic [3:0] CMD_SET_BIT  = 4'd4;
    localparam logic [3:0] CMD_CLR_BIT  = 4'd5;
    localparam logic [3:0] CMD_TGL_BIT  = 4'd6;
    localparam logic [3:0] CMD_WR_BYTE  = 4'd7;
    localparam logic [3:0] CMD_WR_WORD  = 4'd8;
    localparam logic [3:0] CMD_WR_DWORD = 4'd9;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BIT  = 2'd1;
    localparam logic [1:0] STAT_BYTE = 2'd2;
    localparam logic [1:0] STAT_AREA = 2'd3;

    localparam logic [1:0] AREA_BAD = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic       go;
    } bapi_chk_t;

    function automatic logic [2:0] cmd_width(input logic [3:0] cmd);
        logic [2:0] w;
        case (cmd) inside
            CMD_RD_BIT, CMD_RD_BYTE, CMD_SET_BIT, CMD_CLR_BIT,
            CMD_TGL_BIT, CMD_WR_BYTE: w = 3'd1;
            CMD_RD_WORD, CMD_WR_WORD: w = 3'd2;
            CMD_RD_DWORD, CMD_WR_DWORD: w = 3'd4;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

    function automatic logic cmd_is_write(input logic [3:0] cmd);
        return (cmd == CMD_SET_BIT) || (cmd == CMD_CLR_BIT) || (cmd == CMD_TGL_BIT) ||
               (cmd == CMD_WR_BYTE) || (cmd == CMD_WR_WORD) || (cmd == CMD_WR_DWORD);
    endfunction

endpackage

// ===== design/bit_addressable_process_image.sv =====
// Top level of the bit-addressable process image with four interleaved byte banks.
`timescale 1ns / 1ps

// The image holds three areas of AREA_BYTES bytes (inputs, outputs, memory), spread over
// four byte-wide banks so that any 1, 2 or 4 byte access, aligned or not, touches each bank
// at most once. After reset the block zeroes the image, one row of four bytes per cycle, over
// all ceil(3 * AREA_BYTES / 4) rows (768 at the default size), and holds s_ready low meanwhile.
// Each transaction then passes S_IDLE (accept and check), S_READ (bank read) and S_MODIFY
// (modify, write back and load the result register), which waits until the m_ side is free.
// A new transaction is accepted while an earlier result still waits on the m_ side.
module bit_addressable_process_image
    import bapi_pkg::*;
#(
    parameter int AREA_BYTES = AREA_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [1:0]  s_area,
    input  logic [15:0] s_byte_addr,
    input  logic [3:0]  s_bit_addr,
    input  logic [31:0] s_wr_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_rd_data,
    output logic [1:0]  m_status
);

    localparam int ADDR_W = $clog2(3 * AREA_BYTES);
    localparam int ROW_W  = ADDR_W - 2;
    localparam int ROWS   = (3 * AREA_BYTES + 3) / 4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MODIFY
    } state_t;

    state_t            state_reg;
    logic [ROW_W-1:0]  clr_row_reg;
    logic [3:0]        cmd_reg;
    logic [2:0]        bit_reg;
    logic [31:0]       wr_value_reg;
    logic [1:0]        status_reg;
    logic              go_reg;
    logic [ADDR_W-1:0] gaddr_reg;
    logic              m_valid_reg;
    logic [31:0]       m_rd_data_reg;
    logic [1:0]        m_status_reg;

    bapi_chk_t         chk;
    logic [ADDR_W-1:0] gaddr;

    logic [ROW_W-1:0]  lane_row [4];
    logic [1:0]        lane_off [4];
    logic [3:0]        lane_used;
    logic [7:0]        lane_wdata [4];
    logic [3:0]        lane_we;
    logic [3:0]        lane_re;
    logic [7:0]        bank_rdata [4];

    logic [2:0]        width;
    logic              accept;
    logic              out_free;
    logic              finish;
    logic [7:0]        rbyte [4];
    logic [7:0]        bit_mask;
    logic [7:0]        bit_byte;
    logic [31:0]       rd_next;

    bapi_check #(
        .AREA_BYTES (AREA_BYTES),
        .ADDR_W     (ADDR_W)
    ) u_check (
        .cmd       (s_cmd),
        .area      (s_area),
        .byte_addr (s_byte_addr),
        .bit_addr  (s_bit_addr),
        .chk       (chk),
        .gaddr     (gaddr)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == S_MODIFY) && out_free;
    assign width     = cmd_width(cmd_reg);
    assign m_valid   = m_valid_reg;
    assign m_rd_data = m_rd_data_reg;
    assign m_status  = m_status_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            lane_off[k]  = 2'(k) - gaddr_reg[1:0];
            lane_used[k] = ({1'b0, lane_off[k]} < width);
            lane_row[k]  = gaddr_reg[ADDR_W-1:2] + ROW_W'(2'(k) < gaddr_reg[1:0]);
        end
        for (int i = 0; i < 4; i++) begin
            rbyte[i] = bank_rdata[2'(gaddr_reg[1:0] + 2'(i))];
        end
    end

    always_comb begin
        bit_mask = 8'h01 << bit_reg;
        case (cmd_reg)
            CMD_SET_BIT: bit_byte = rbyte[0] | bit_mask;
            CMD_CLR_BIT: bit_byte = rbyte[0] & ~bit_mask;
            default:     bit_byte = rbyte[0] ^ bit_mask;
        endcase
    end

    always_comb begin
        rd_next = '0;
        if (go_reg) begin
            case (cmd_reg)
                CMD_RD_BIT:   rd_next = {31'd0, rbyte[0][bit_reg]};
                CMD_RD_BYTE:  rd_next = {24'd0, rbyte[0]};
                CMD_RD_WORD:  rd_next = {16'd0, rbyte[1], rbyte[0]};
                CMD_RD_DWORD: rd_next = {rbyte[3], rbyte[2], rbyte[1], rbyte[0]};
                default:      rd_next = '0;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (state_reg == S_CLEAR) begin
                lane_wdata[k] = 8'h00;
                lane_we[k]    = 1'b1;
            end else begin
                if ((cmd_reg == CMD_SET_BIT) || (cmd_reg == CMD_CLR_BIT) ||
                    (cmd_reg == CMD_TGL_BIT)) begin
                    lane_wdata[k] = bit_byte;
                end else begin
                    lane_wdata[k] = wr_value_reg[{lane_off[k], 3'b000} +: 8];
                end
                lane_we[k] = finish && go_reg && cmd_is_write(cmd_reg) && lane_used[k];
            end
            lane_re[k] = (state_reg == S_READ) && go_reg && lane_used[k];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        bapi_bank #(
            .DEPTH (ROWS),
            .AW    (ROW_W)
        ) u_bank (
            .aclk  (aclk),
            .we    (lane_we[g]),
            .waddr ((state_reg == S_CLEAR) ? clr_row_reg : lane_row[g]),
            .wdata (lane_wdata[g]),
            .re    (lane_re[g]),
            .raddr (lane_row[g]),
            .rdata (bank_rdata[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_row_reg <= clr_row_reg + ROW_W'(1);
                    if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_MODIFY;
                end
                S_MODIFY: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_cmd;
            bit_reg      <= s_bit_addr[2:0];
            wr_value_reg <= s_wr_value;
            status_reg   <= chk.status;
            go_reg       <= chk.go;
            gaddr_reg    <= gaddr;
        end
        if (finish) begin
            m_rd_data_reg <= rd_next;
            m_status_reg  <= status_reg;
        end
    end

`ifndef SYNTHESIS
    a_err_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_OK)) |-> (m_rd_data == 32'd0))
        else $error("Failed transaction returned nonzero data.");

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("Input accepted before the image was cleared.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Second transaction accepted while one is in progress.");

    a_no_write_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_MODIFY) && !go_reg) |-> (lane_we == 4'b0000))
        else $error("Image written by a failed or unused command.");
`endif

endmodule

// ===== design/bapi_bank.sv =====
// One byte-wide image bank with a registered synchronous read port.
`timescale 1ns / 1ps

module bapi_bank #(
    parameter int DEPTH = 768,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bapi_check.sv =====
// Command checks in priority order and flat image address calculation.
`timescale 1ns / 1ps

module bapi_check
    import bapi_pkg::*;
#(
    parameter int AREA_BYTES = AREA_BYTES_DEF,
    parameter int ADDR_W     = 12
) (
    input  logic [3:0]        cmd,
    input  logic [1:0]        area,
    input  logic [15:0]       byte_addr,
    input  logic [3:0]        bit_addr,
    output bapi_chk_t         chk,
    output logic [ADDR_W-1:0] gaddr
);

    localparam logic [17:0] AREA_LIM = 18'(AREA_BYTES);

    logic [2:0]        width;
    logic [17:0]       end_addr;
    logic [ADDR_W-1:0] base;

    always_comb begin
        width    = cmd_width(cmd);
        end_addr = {2'b00, byte_addr} + {15'd0, width};
        chk      = '{status: STAT_OK, go: 1'b0};
        if (width != 3'd0) begin
            if (bit_addr > 4'd7) begin
                chk.status = STAT_BIT;
            end else if (end_addr > AREA_LIM) begin
                chk.status = STAT_BYTE;
            end else if (area == AREA_BAD) begin
                chk.status = STAT_AREA;
            end else begin
                chk.go = 1'b1;
            end
        end
    end

    always_comb begin
        case (area)
            2'd0:    base = '0;
            2'd1:    base = ADDR_W'(AREA_BYTES);
            default: base = ADDR_W'(2 * AREA_BYTES);
        endcase
        gaddr = base + ADDR_W'(byte_addr);
    end

endmodule

// ===== dv/bit_addressable_process_image_tb.sv =====
// Testbench for the process image: directed and random commands against a behavioral image.
`timescale 1ns / 1ps

module bit_addressable_process_image_tb
    import bapi_pkg::*;
();

    localparam int AREA_BYTES = AREA_BYTES_DEF;
    localparam int IMAGE_BYTES = 3 * AREA_BYTES;
    localparam logic [3:0] CMD_SPARE_FIRST = 4'd10;
    localparam logic [3:0] CMD_SPARE_LAST = 4'd15;
    localparam logic [3:0] MAX_BIT_IDX = 4'd7;
    localparam int PHASE_ITEMS = 140;

    typedef struct {
        logic [31:0] rd_data;
        logic [1:0]  status;
    } image_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_cmd = CMD_RD_BIT;
    logic [1:0]  s_area = 2'd0;
    logic [15:0] s_byte_addr = 16'd0;
    logic [3:0]  s_bit_addr = 4'd0;
    logic [31:0] s_wr_value = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_rd_data;
    logic [1:0]  m_status;

    logic [7:0]   image_mirror [IMAGE_BYTES];
    image_reply_t replies_due [$];
    int           mismatches = 0;
    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;

    bit_addressable_process_image #(
        .AREA_BYTES(AREA_BYTES)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_area(s_area),
        .s_byte_addr(s_byte_addr),
        .s_bit_addr(s_bit_addr),
        .s_wr_value(s_wr_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rd_data(m_rd_data),
        .m_status(m_status)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic image_reply_t image_access(input logic [3:0] cmd, input logic [1:0] area,
                                                  input logic [15:0] baddr,
                                                  input logic [3:0] bit_idx,
                                                  input logic [31:0] value);
        image_reply_t reply;
        int width;
        int base;
        logic [7:0] mask;
        reply.rd_data = 32'd0;
        reply.status = STAT_OK;
        case (cmd)
            CMD_RD_BIT, CMD_RD_BYTE, CMD_SET_BIT, CMD_CLR_BIT, CMD_TGL_BIT, CMD_WR_BYTE: width = 1;
            CMD_RD_WORD, CMD_WR_WORD: width = 2;
            CMD_RD_DWORD, CMD_WR_DWORD: width = 4;
            default: width = 0;
        endcase
        if (width == 0) begin
            return reply;
        end
        if (bit_idx > MAX_BIT_IDX) begin
            reply.status = STAT_BIT;
        end else if (int'(baddr) + width > AREA_BYTES) begin
            reply.status = STAT_BYTE;
        end else if (area == AREA_BAD) begin
            reply.status = STAT_AREA;
        end else begin
            base = int'(area) * AREA_BYTES + int'(baddr);
            mask = 8'h01 << bit_idx;
            case (cmd)
                CMD_RD_BIT: reply.rd_data = {31'd0, image_mirror[base][bit_idx[2:0]]};
                CMD_RD_BYTE, CMD_RD_WORD, CMD_RD_DWORD: begin
                    for (int i = 0; i < width; i++) begin
                        reply.rd_data[8*i +: 8] = image_mirror[base + i];
                    end
                end
                CMD_SET_BIT: image_mirror[base] = image_mirror[base] | mask;
                CMD_CLR_BIT: image_mirror[base] = image_mirror[base] & ~mask;
                CMD_TGL_BIT: image_mirror[base] = image_mirror[base] ^ mask;
                default: begin
                    for (int i = 0; i < width; i++) begin
                        image_mirror[base + i] = value[8*i +: 8];
                    end
                end
            endcase
        end
        return reply;
    endfunction

    task automatic send_command(input logic [3:0] cmd, input logic [1:0] area,
                                input logic [15:0] baddr, input logic [3:0] bit_idx,
                                input logic [31:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_area <= area;
        s_byte_addr <= baddr;
        s_bit_addr <= bit_idx;
        s_wr_value <= value;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(image_access(cmd, area, baddr, bit_idx, value));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_random_command(output bit counted);
        logic [3:0]  cmd;
        logic [1:0]  area;
        logic [15:0] baddr;
        logic [3:0]  bit_idx;
        int          pick;
        cmd = ($urandom_range(9) == 0) ? 4'($urandom_range(CMD_SPARE_LAST))
                                       : 4'($urandom_range(CMD_WR_DWORD));
        area = ($urandom_range(7) == 0) ? 2'($urandom_range(AREA_BAD)) : 2'($urandom_range(2));
        pick = $urandom_range(9);
        if (pick < 6) begin
            baddr = 16'($urandom_range(7));
        end else if (pick < 8) begin
            baddr = 16'($urandom_range(AREA_BYTES - 1, AREA_BYTES - 8));
        end else if (pick < 9) begin
            baddr = 16'($urandom_range(AREA_BYTES - 1));
        end else begin
            baddr = 16'($urandom);
        end
        bit_idx = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
        send_command(cmd, area, baddr, bit_idx, $urandom);
        counted = (cmd <= CMD_WR_DWORD);
    endtask

    task automatic test_after_reset();
        send_command(CMD_RD_DWORD, 2'd0, 16'd0, 4'd0, 32'd0);
        send_command(CMD_RD_DWORD, 2'd2, 16'(AREA_BYTES - 4), 4'd0, 32'd0);
        send_command(CMD_RD_BIT, 2'd1, 16'(AREA_BYTES - 1), 4'd0, 32'd0);
    endtask

    task automatic test_wide_access();
        send_command(CMD_WR_DWORD, 2'd1, 16'(AREA_BYTES - 4), 4'd0, 32'hFFFF_FFFF);
        send_command(CMD_RD_DWORD, 2'd1, 16'(AREA_BYTES - 4), 4'd0, 32'd0);
        send_command(CMD_WR_WORD, 2'd0, 16'd1, 4'd0, 32'h0000_A5C3);
        send_command(CMD_RD_DWORD, 2'd0, 16'd0, 4'd0, 32'd0);
        send_command(CMD_WR_BYTE, 2'd2, 16'd0, 4'd0, 32'h1234_5678);
        send_command(CMD_RD_BYTE, 2'd2, 16'd0, 4'd0, 32'd0);
    endtask

    task automatic test_bit_commands();
        send_command(CMD_SET_BIT, 2'd0, 16'd0, 4'd7, 32'd0);
        send_command(CMD_TGL_BIT, 2'd0, 16'd1, 4'd0, 32'd0);
        send_command(CMD_CLR_BIT, 2'd0, 16'd2, 4'd7, 32'd0);
        send_command(CMD_RD_BIT, 2'd0, 16'd0, 4'd7, 32'd0);
        send_command(CMD_RD_WORD, 2'd0, 16'd0, 4'd0, 32'd0);
    endtask

    task automatic test_check_order();
        send_command(CMD_RD_BYTE, 2'd0, 16'd0, 4'd8, 32'd0);
        send_command(CMD_WR_DWORD, AREA_BAD, 16'(AREA_BYTES - 3), 4'd15, 32'hDEAD_BEEF);
        send_command(CMD_RD_DWORD, AREA_BAD, 16'(AREA_BYTES - 3), 4'd0, 32'd0);
        send_command(CMD_WR_WORD, 2'd2, 16'(AREA_BYTES - 1), 4'd0, 32'hFFFF_FFFF);
        send_command(CMD_RD_BIT, 2'd1, 16'hFFFF, 4'd7, 32'd0);
        send_command(CMD_RD_BYTE, AREA_BAD, 16'd0, 4'd0, 32'd0);
    endtask

    task automatic test_spare_commands();
        send_command(CMD_SPARE_LAST, AREA_BAD, 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_FIRST, 2'd0, 16'd0, 4'd0, 32'h5555_5555);
        send_command(CMD_RD_DWORD, 2'd0, 16'd0, 4'd0, 32'd0);
    endtask

    task automatic test_random(input int items, input int idle_pct, input int stall_pct);
        int done;
        bit counted;
        done = 0;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        while (done < items) begin
            send_random_command(counted);
            if (counted) begin
                done++;
            end
        end
    endtask

    task automatic test_resume_after_drain();
        wait_drained();
        test_random(20, 0, 0);
    endtask

    always @(posedge aclk) begin
        image_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $error("Unexpected transaction: rd_data %h, status %0d", m_rd_data, m_status);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (m_rd_data !== want.rd_data) begin
                    $error("rd_data mismatch: expected %h, actual %h", want.rd_data, m_rd_data);
                    mismatches++;
                end
                if (m_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_status);
                    mismatches++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        foreach (image_mirror[i]) begin
            image_mirror[i] = 8'h00;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_after_reset();
        test_wide_access();
        test_bit_commands();
        test_check_order();
        test_spare_commands();
        test_random(PHASE_ITEMS, 0, 0);
        test_random(PHASE_ITEMS, 65, 0);
        test_resume_after_drain();
        test_random(PHASE_ITEMS, 0, 65);
        test_random(PHASE_ITEMS, 36, 36);
        test_random(PHASE_ITEMS / 4, 0, 0);
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
